// ===== rtl/tcco_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the tilt-compensated compass pipeline.
// No dependencies; imported by tcco_sqrt, tcco_cordic and the top level.
package tcco_pkg;

    localparam int DATA_W       = 16;
    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 24;
    localparam int HEAD_W       = 15;
    localparam int LED_W        = 3;
    localparam int RAD_W        = 40;   // (sum of squares) << 8
    localparam int ROOT_W       = 21;   // rounded root, 4 fraction bits
    localparam int NORM_W       = 30;   // normalized vector, |v| < 2^29
    localparam int XY_W         = 34;   // CORDIC x/y with gain headroom
    localparam int Z_W          = 27;   // angle in 2^-16 degree
    localparam int ATAN_TAB_LEN = 24;

    localparam logic signed [Z_W-1:0] DEG180_Q16 = 27'sd11796480;

    // Fields carried alongside the square roots.
    typedef struct packed {
        logic              accel_zero;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } tcco_side_t;

    // atan(2^-i) in 2^-16 degree, rounded
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117304;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            5'd22: v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tcco_sqrt.sv =====
`timescale 1ns / 1ps
// Three-lane pipelined digit-by-digit square root, rounded to nearest.
// Depends on tcco_pkg. One result bit per stage, sideband travels along.
module tcco_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  tcco_pkg::tcco_side_t        in_side,
    input  logic [tcco_pkg::RAD_W-1:0]  rad_a,
    input  logic [tcco_pkg::RAD_W-1:0]  rad_bp,
    input  logic [tcco_pkg::RAD_W-1:0]  rad_dr,
    output logic                        out_valid,
    output tcco_pkg::tcco_side_t        out_side,
    output logic [tcco_pkg::ROOT_W-1:0] root_a,
    output logic [tcco_pkg::ROOT_W-1:0] root_bp,
    output logic [tcco_pkg::ROOT_W-1:0] root_dr
);
    import tcco_pkg::*;

    localparam int STEPS = RAD_W / 2;
    localparam int REM_W = STEPS + 3;
    localparam int LANES = 3;

    logic [RAD_W-1:0]  rad_reg  [LANES][STEPS+1];
    logic [RAD_W-1:0]  rad_next [LANES][STEPS+1];
    logic [REM_W-1:0]  rem_reg  [LANES][STEPS+1];
    logic [REM_W-1:0]  rem_next [LANES][STEPS+1];
    logic [STEPS-1:0]  root_reg  [LANES][STEPS+1];
    logic [STEPS-1:0]  root_next [LANES][STEPS+1];
    logic [ROOT_W-1:0] res_reg  [LANES];
    logic [ROOT_W-1:0] res_next [LANES];
    logic [RAD_W-1:0]  rad_in   [LANES];
    logic [STEPS:0]    v_reg;
    logic              vo_reg;
    tcco_side_t        side_reg [STEPS+1];
    tcco_side_t        so_reg;

    assign rad_in[0] = rad_a;
    assign rad_in[1] = rad_bp;
    assign rad_in[2] = rad_dr;

    always_comb begin : step_logic
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;
        for (int l = 0; l < LANES; l++) begin
            rad_next[l][0]  = rad_in[l];
            rem_next[l][0]  = '0;
            root_next[l][0] = '0;
            for (int j = 0; j < STEPS; j++) begin
                rem_sh = {rem_reg[l][j][REM_W-3:0], rad_reg[l][j][RAD_W-1 -: 2]};
                trial  = {1'b0, root_reg[l][j], 2'b01};
                ge     = (rem_sh >= trial);
                rem_next[l][j+1]  = ge ? (rem_sh - trial) : rem_sh;
                root_next[l][j+1] = {root_reg[l][j][STEPS-2:0], ge};
                rad_next[l][j+1]  = rad_reg[l][j] << 2;
            end
            // round up when the remainder exceeds the root
            res_next[l] = {1'b0, root_reg[l][STEPS]}
                        + ROOT_W'(rem_reg[l][STEPS] > {3'b000, root_reg[l][STEPS]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end else if (ce) begin
            v_reg  <= {v_reg[STEPS-1:0], in_valid};
            vo_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg     <= rad_next;
            rem_reg     <= rem_next;
            root_reg    <= root_next;
            res_reg     <= res_next;
            side_reg[0] <= in_side;
            for (int j = 0; j < STEPS; j++) begin
                side_reg[j+1] <= side_reg[j];
            end
            so_reg <= side_reg[STEPS];
        end
    end

    assign out_valid = vo_reg;
    assign out_side  = so_reg;
    assign root_a    = res_reg[0];
    assign root_bp   = res_reg[1];
    assign root_dr   = res_reg[2];

endmodule

// ===== rtl/tcco_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: angle of (x, y) in 2^-16 degree.
// Depends on tcco_pkg. Half-turn pre-rotation stage, then one stage per step.
module tcco_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             ce,
    input  logic                             in_valid,
    input  logic                             in_zero,
    input  logic signed [tcco_pkg::NORM_W-1:0] in_x,
    input  logic signed [tcco_pkg::NORM_W-1:0] in_y,
    output logic                             out_valid,
    output logic                             out_zero,
    output logic signed [tcco_pkg::Z_W-1:0]  out_z
);
    import tcco_pkg::*;

    localparam int N = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;

    logic signed [XY_W-1:0] x_reg  [N+1];
    logic signed [XY_W-1:0] x_next [N+1];
    logic signed [XY_W-1:0] y_reg  [N+1];
    logic signed [XY_W-1:0] y_next [N+1];
    logic signed [Z_W-1:0]  z_reg  [N+1];
    logic signed [Z_W-1:0]  z_next [N+1];
    logic [N:0]             zf_reg;
    logic [N:0]             v_reg;

    always_comb begin : step_logic
        logic signed [XY_W-1:0] xe;
        logic signed [XY_W-1:0] ye;
        xe = XY_W'(in_x);
        ye = XY_W'(in_y);
        if (in_x < 0) begin
            x_next[0] = -xe;
            y_next[0] = -ye;
            z_next[0] = (in_y >= 0) ? DEG180_Q16 : -DEG180_Q16;
        end else begin
            x_next[0] = xe;
            y_next[0] = ye;
            z_next[0] = '0;
        end
        for (int i = 0; i < N; i++) begin
            if (!y_reg[i][XY_W-1]) begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_q16(5'(i));
            end else begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_q16(5'(i));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            zf_reg <= {zf_reg[N-1:0], in_zero};
        end
    end

    assign out_valid = v_reg[N];
    assign out_zero  = zf_reg[N];
    assign out_z     = z_reg[N];

endmodule

// ===== rtl/tilt_compensated_compass_octant_unit.sv =====
`timescale 1ns / 1ps
// Top level of the tilt-compensated compass: heading and north-LED index.
// Depends on tcco_pkg, tcco_sqrt and tcco_cordic.
//
// Usage:
//   s_ channel: one accelerometer + magnetometer sample per item.
//   m_ channel: one result item per input item, in order.
//   Fully pipelined, no state between samples: one item per cycle
//   sustained while the receiver keeps up (a held result stalls it). From
//   input accept to m_tvalid an item passes: 2 input and square stages,
//   22 stages of the three-lane square root (input register, one root bit
//   per digit stage, rounding register), 4 product stages, 5 normalize
//   stages, the CORDIC pre-rotation and its steps, and the output register.
//   An all-zero vector gives heading 0 (LED 4).
//   Reset (aresetn low, synchronous) drops every item in flight.
//   A stalled receiver holds the output register; the pipeline keeps
//   moving and fills bubbles until an item reaches its last stage, then
//   everything freezes and s_tready drops in the same cycle.
module tilt_compensated_compass_octant_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (16 bits each)
    input  logic [tcco_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // heading_angle [14:0] signed, led_index [17:15], zero padding [23:18]
    output logic [tcco_pkg::M_TDATA_W-1:0]     m_tdata
);
    import tcco_pkg::*;

    localparam logic [LED_W-1:0] LED_N  = 3'd0;
    localparam logic [LED_W-1:0] LED_NW = 3'd1;
    localparam logic [LED_W-1:0] LED_W_ = 3'd2;
    localparam logic [LED_W-1:0] LED_SW = 3'd3;
    localparam logic [LED_W-1:0] LED_S  = 3'd4;
    localparam logic [LED_W-1:0] LED_SE = 3'd5;
    localparam logic [LED_W-1:0] LED_E  = 3'd6;
    localparam logic [LED_W-1:0] LED_NE = 3'd7;
    localparam logic signed [HEAD_W-1:0] HEAD_MAX = 15'sd11520;

    // ---------------- stall control ----------------
    logic ce;
    logic out_load;
    logic cord_valid;

    assign out_load = !m_tvalid || m_tready;
    assign ce       = out_load || !cord_valid;
    assign s_tready = ce;

    // ---------------- T0: input register ----------------
    logic                     v0_reg;
    logic signed [DATA_W-1:0] ax0_reg, ay0_reg, az0_reg, mx0_reg, my0_reg, mz0_reg;

    // ---------------- T1: squares ----------------
    logic        v1_reg;
    logic [31:0] sqx_reg, sqy_reg, sqz_reg;
    tcco_side_t  side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (ce) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ax0_reg <= s_tdata[15:0];
            ay0_reg <= s_tdata[31:16];
            az0_reg <= s_tdata[47:32];
            mx0_reg <= s_tdata[63:48];
            my0_reg <= s_tdata[79:64];
            mz0_reg <= s_tdata[95:80];
            sqx_reg <= 32'(ax0_reg * ax0_reg);
            sqy_reg <= 32'(ay0_reg * ay0_reg);
            sqz_reg <= 32'(az0_reg * az0_reg);
            side1_reg.accel_zero <= (ax0_reg == '0) && (ay0_reg == '0) && (az0_reg == '0);
            side1_reg.ax <= ax0_reg;
            side1_reg.ay <= ay0_reg;
            side1_reg.mx <= mx0_reg;
            side1_reg.my <= my0_reg;
            side1_reg.mz <= mz0_reg;
        end
    end

    // ---------------- square roots ----------------
    logic [RAD_W-1:0]  rad_a, rad_bp, rad_dr;
    logic              sq_valid;
    tcco_side_t        sq_side;
    logic [ROOT_W-1:0] root_a, root_bp, root_dr;

    assign rad_bp = {(RAD_W-8)'({1'b0, sqy_reg} + {1'b0, sqz_reg}), 8'h00};
    assign rad_dr = {(RAD_W-8)'({1'b0, sqx_reg} + {1'b0, sqz_reg}), 8'h00};
    assign rad_a  = {(RAD_W-8)'({2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg}),
                     8'h00};

    tcco_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v1_reg),
        .in_side   (side1_reg),
        .rad_a     (rad_a),
        .rad_bp    (rad_bp),
        .rad_dr    (rad_dr),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root_a    (root_a),
        .root_bp   (root_bp),
        .root_dr   (root_dr)
    );

    // ---------------- P1..P4: horizontal vector ----------------
    // X = a*(mx*bp + 16*mz*ax)
    // Y = 256*mx*ay*ax + my*dr*a - 16*mz*ay*bp
    logic [3:0]               pv_reg;
    logic                     pz1_reg, pz2_reg, pz3_reg;
    logic signed [DATA_W-1:0] mx1_reg, my1_reg, mx2_reg, my2_reg, mx3_reg, my3_reg;
    logic [ROOT_W-1:0]        a1_reg, bp1_reg, a2_reg;
    logic signed [37:0]       t1_reg;
    logic signed [31:0]       t2_reg, t3_reg, t5_reg;
    logic [41:0]              t4_reg;
    logic signed [39:0]       u_reg;
    logic signed [47:0]       v1p_reg;
    logic signed [37:0]       wlo_reg, whi_reg;
    logic signed [53:0]       q_reg;
    logic signed [42:0]       xlo_reg;
    logic signed [41:0]       xhi_reg;
    logic signed [63:0]       y3_reg;
    logic signed [63:0]       hx_reg, hy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (ce) begin
            pv_reg <= {pv_reg[2:0], sq_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // P1
            t1_reg  <= sq_side.mx * $signed({1'b0, root_bp});
            t2_reg  <= sq_side.mz * sq_side.ax;
            t3_reg  <= sq_side.ay * sq_side.ax;
            t4_reg  <= root_dr * root_a;
            t5_reg  <= sq_side.mz * sq_side.ay;
            a1_reg  <= root_a;
            bp1_reg <= root_bp;
            mx1_reg <= sq_side.mx;
            my1_reg <= sq_side.my;
            pz1_reg <= sq_side.accel_zero;
            // P2
            u_reg   <= t1_reg + (40'(t2_reg) <<< 4);
            v1p_reg <= mx1_reg * t3_reg;
            wlo_reg <= my1_reg * $signed({1'b0, t4_reg[20:0]});
            whi_reg <= my1_reg * $signed({1'b0, t4_reg[41:21]});
            q_reg   <= t5_reg * $signed({1'b0, bp1_reg});
            a2_reg  <= a1_reg;
            mx2_reg <= mx1_reg;
            my2_reg <= my1_reg;
            pz2_reg <= pz1_reg;
            // P3
            xlo_reg <= $signed({1'b0, a2_reg}) * $signed({1'b0, u_reg[19:0]});
            xhi_reg <= $signed({1'b0, a2_reg}) * $signed(u_reg[39:20]);
            y3_reg  <= (64'(v1p_reg) <<< 8) + (64'(whi_reg) <<< 21) + 64'(wlo_reg)
                     - (64'(q_reg) <<< 4);
            mx3_reg <= mx2_reg;
            my3_reg <= my2_reg;
            pz3_reg <= pz2_reg;
            // P4: an all-zero accelerometer reading falls back to the raw field
            if (pz3_reg) begin
                hx_reg <= 64'(mx3_reg);
                hy_reg <= 64'(my3_reg);
            end else begin
                hx_reg <= (64'(xhi_reg) <<< 20) + 64'(xlo_reg);
                hy_reg <= y3_reg;
            end
        end
    end

    // ---------------- N1..N5: normalize to [2^28, 2^29) ----------------
    // Shift left by 62-p (exact), then arithmetic right by 34: this is a
    // left shift for small vectors and a floor right shift for large ones.
    logic [4:0]         nv_reg;
    logic signed [63:0] nx1_reg, ny1_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg;
    logic signed [63:0] nx4_reg, ny4_reg;
    logic [63:0]        nm_reg;
    logic [2:0]         grp_reg;
    logic [7:0]         byte_reg;
    logic               nz2_reg, nz3_reg, nz4_reg, nz5_reg;
    logic [5:0]         sh3_reg;
    logic [2:0]         sh4_reg;
    logic signed [NORM_W-1:0] nx5_reg, ny5_reg;
    logic [63:0]        abs_x, abs_y;
    logic [2:0]         grp_sel;
    logic [2:0]         bit_sel;
    logic [63:0]        fx, fy;

    assign abs_x = hx_reg[63] ? 64'(-hx_reg) : 64'(hx_reg);
    assign abs_y = hy_reg[63] ? 64'(-hy_reg) : 64'(hy_reg);

    always_comb begin
        grp_sel = '0;
        for (int g = 0; g < 8; g++) begin
            if (|nm_reg[8*g +: 8]) begin
                grp_sel = 3'(g);
            end
        end
        bit_sel = '0;
        for (int b = 0; b < 8; b++) begin
            if (byte_reg[b]) begin
                bit_sel = 3'(b);
            end
        end
    end

    assign fx = 64'(nx4_reg) << sh4_reg;
    assign fy = 64'(ny4_reg) << sh4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= '0;
        end else if (ce) begin
            nv_reg <= {nv_reg[3:0], pv_reg[3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // N1
            nm_reg   <= abs_x | abs_y;
            nx1_reg  <= hx_reg;
            ny1_reg  <= hy_reg;
            // N2
            grp_reg  <= grp_sel;
            byte_reg <= nm_reg[8*grp_sel +: 8];
            nz2_reg  <= (nm_reg == '0);
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            // N3
            sh3_reg  <= 6'd62 - {grp_reg, bit_sel};
            nz3_reg  <= nz2_reg;
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            // N4: whole bytes
            nx4_reg  <= nx3_reg <<< {sh3_reg[5:3], 3'b000};
            ny4_reg  <= ny3_reg <<< {sh3_reg[5:3], 3'b000};
            sh4_reg  <= sh3_reg[2:0];
            nz4_reg  <= nz3_reg;
            // N5: remaining bits, keep the top NORM_W
            nx5_reg  <= $signed(fx[63:34]);
            ny5_reg  <= $signed(fy[63:34]);
            nz5_reg  <= nz4_reg;
        end
    end

    // ---------------- CORDIC ----------------
    logic                  cord_zero;
    logic signed [Z_W-1:0] cord_z;

    tcco_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (nv_reg[4]),
        .in_zero   (nz5_reg),
        .in_x      (nx5_reg),
        .in_y      (ny5_reg),
        .out_valid (cord_valid),
        .out_zero  (cord_zero),
        .out_z     (cord_z)
    );

    // ---------------- output: round, saturate, sector ----------------
    logic signed [Z_W:0]      z_rnd;
    logic signed [Z_W-10:0]   h_wide;
    logic signed [HEAD_W-1:0] head_next;
    logic [LED_W-1:0]         led_next;
    logic signed [HEAD_W-1:0] head_reg;
    logic [LED_W-1:0]         led_reg;
    logic                     m_tvalid_reg;

    assign z_rnd  = (Z_W+1)'(cord_z) + (Z_W+1)'(512);
    assign h_wide = z_rnd[Z_W:10];

    always_comb begin
        if (cord_zero) begin
            head_next = '0;
        end else if (h_wide > (Z_W-9)'(HEAD_MAX)) begin
            head_next = HEAD_MAX;
        end else if (h_wide < -(Z_W-9)'(HEAD_MAX)) begin
            head_next = -HEAD_MAX;
        end else begin
            head_next = h_wide[HEAD_W-1:0];
        end

        if (head_next >= -15'sd1440 && head_next < 15'sd1440) begin
            led_next = LED_S;
        end else if (head_next >= -15'sd4320 && head_next < -15'sd1440) begin
            led_next = LED_SE;
        end else if (head_next >= -15'sd7200 && head_next < -15'sd4320) begin
            led_next = LED_E;
        end else if (head_next >= -15'sd10080 && head_next < -15'sd7200) begin
            led_next = LED_NE;
        end else if (head_next >= 15'sd7200 && head_next < 15'sd10080) begin
            led_next = LED_NW;
        end else if (head_next >= 15'sd4320 && head_next < 15'sd7200) begin
            led_next = LED_W_;
        end else if (head_next >= 15'sd1440 && head_next < 15'sd4320) begin
            led_next = LED_SW;
        end else begin
            led_next = LED_N;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= cord_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            head_reg <= head_next;
            led_reg  <= led_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, led_reg, head_reg};

    // ---------------- assertions ----------------
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && cord_valid))
        else $error("pipeline stalled without a blocked result");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (head_reg <= HEAD_MAX && head_reg >= -HEAD_MAX))
        else $error("heading out of range");

    a_led_south: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head_reg >= -15'sd1440 && head_reg < 15'sd1440) |-> led_reg == LED_S)
        else $error("south sector mismatch");

    a_led_north: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (head_reg >= 15'sd10080 || head_reg < -15'sd10080))
        |-> led_reg == LED_N)
        else $error("north sector mismatch");

endmodule
